FILE: sv/arp_cache_resolver_unit_assert.svh
// Assertion macros for the ARP cache resolver.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ARP_CACHE_RESOLVER_UNIT_ASSERT_SVH
`define ARP_CACHE_RESOLVER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define ARP_CR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ARP_CR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/arp_cr_pkg.sv
package arp_cr_pkg;

  // Field widths
  localparam int unsigned IP_W  = 32;
  localparam int unsigned MAC_W = 48;
  localparam int unsigned TAG_W = 16;

  // Default sizes
  localparam int unsigned TABLE_ENTRIES_DEF = 16;
  localparam int unsigned WAIT_SLOTS_DEF    = 4;

  // Result buffer: one request causes at most four results
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_IDX_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = RES_IDX_W + 1;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_IP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_MAC = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_MAC = 3'd4;

  // Register reset values
  localparam logic [IP_W-1:0]  FIXED_IP_RST  = 32'h0202_000A;
  localparam logic [MAC_W-1:0] FIXED_MAC_RST = 48'h5255_0A00_0202;
  localparam logic [MAC_W-1:0] PROBE_MAC_RST = 48'h5254_0012_3456;
  localparam logic [MAC_W-1:0] BCAST_MAC     = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    CMD_REPLY   = 2'd0,
    CMD_REQUEST = 2'd1,
    CMD_RESOLVE = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_REQUEST = 2'd1,
    KIND_REPLY   = 2'd2,
    KIND_DROP    = 2'd3
  } kind_e;

  // Lookup wave passed from cell to cell
  typedef struct packed {
    logic             live;
    logic             hit;
    logic [MAC_W-1:0] hit_mac;
    logic             free;
  } scan_rec_t;

  // Learn write broadcast to all cells
  typedef struct packed {
    logic             en;
    logic             sel_hit;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } entry_wr_t;

  // One buffered result
  typedef struct packed {
    kind_e            kind;
    logic [TAG_W-1:0] tag;
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  ip;
  } res_t;

endpackage

FILE: sv/arp_cr_entry_cell.sv
module arp_cr_entry_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [arp_cr_pkg::IP_W-1:0]  query_ip_i,
  input  arp_cr_pkg::scan_rec_t        rec_i,
  output arp_cr_pkg::scan_rec_t        rec_o,
  input  arp_cr_pkg::entry_wr_t        wr_i
);
  import arp_cr_pkg::*;

  logic             valid_q;
  logic [IP_W-1:0]  ip_q;
  logic [MAC_W-1:0] mac_q;
  logic             hit_mark_q, hit_mark_d;
  logic             free_mark_q, free_mark_d;
  logic             hit_here, free_here, wr_sel;
  scan_rec_t        rec_q, rec_d;

  // Match locally, keep the first hit and first free slot seen so far
  always_comb begin
    hit_here  = valid_q && (ip_q == query_ip_i) && !rec_i.hit;
    free_here = !valid_q && !rec_i.free;
    rec_d         = rec_i;
    rec_d.hit     = rec_i.hit | hit_here;
    rec_d.hit_mac = hit_here ? mac_q : rec_i.hit_mac;
    rec_d.free    = rec_i.free | free_here;
    hit_mark_d    = rec_i.live ? hit_here : hit_mark_q;
    free_mark_d   = rec_i.live ? free_here : free_mark_q;
  end

  // Pass the wave on to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q       <= '0;
      hit_mark_q  <= 1'b0;
      free_mark_q <= 1'b0;
    end else begin
      rec_q       <= rec_d;
      hit_mark_q  <= hit_mark_d;
      free_mark_q <= free_mark_d;
    end
  end

  assign rec_o  = rec_q;
  assign wr_sel = wr_i.en && (wr_i.sel_hit ? hit_mark_q : free_mark_q);

  // Hold the entry valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_sel) begin
      valid_q <= 1'b1;
    end
  end

  // Learn address pair
  always_ff @(posedge clk_i) begin
    if (wr_sel) begin
      ip_q  <= wr_i.ip;
      mac_q <= wr_i.mac;
    end
  end

endmodule

FILE: sv/arp_cache_resolver_unit.sv
// ARP cache resolver. A request is taken when start is high and busy is low;
// results come out one per cycle on strobe_o, with last_o on the final one,
// and cannot be held off, so the receiver must take each in its cycle. The
// learned table is a chain of TABLE_ENTRIES-1 cells that a lookup walks one
// cell per cycle before the request reaches a decision. A received reply then
// scans the WAIT_SLOTS queue one slot per cycle, and a resolve miss scans it
// until the lowest free slot; any results follow, and the last result is on
// the ports in the first cycle with busy low. The user must write
// configuration only while busy is low; the block itself does not enforce it.
module arp_cache_resolver_unit #(
  parameter int unsigned TABLE_ENTRIES = arp_cr_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned WAIT_SLOTS    = arp_cr_pkg::WAIT_SLOTS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration
  input  logic                               cfg_we_i,
  input  logic [arp_cr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [arp_cr_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  // Request
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         cmd_i,
  input  logic [arp_cr_pkg::IP_W-1:0]        sender_ip_i,
  input  logic [arp_cr_pkg::MAC_W-1:0]       sender_mac_i,
  input  logic [arp_cr_pkg::IP_W-1:0]        target_ip_i,
  input  logic [arp_cr_pkg::TAG_W-1:0]       packet_tag_i,
  // Results
  output logic                               strobe_o,
  output logic [1:0]                         kind_o,
  output logic [arp_cr_pkg::TAG_W-1:0]       packet_tag_res_o,
  output logic [arp_cr_pkg::MAC_W-1:0]       dest_mac_o,
  output logic [arp_cr_pkg::IP_W-1:0]        target_ip_res_o,
  output logic                               last_o
);
  import arp_cr_pkg::*;

  localparam int unsigned WIDX_W = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;
  localparam logic [WIDX_W-1:0] WIDX_LAST = WIDX_W'(WAIT_SLOTS - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_WAIT = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic                 accept;
  logic                 launch_q;

  // Request registers
  cmd_e                 cmd_q;
  logic [IP_W-1:0]      sip_q, tip_q;
  logic [MAC_W-1:0]     smac_q;
  logic [TAG_W-1:0]     tag_q;

  // Configuration registers
  logic [IP_W-1:0]      own_ip_q, fixed_ip_q;
  logic [MAC_W-1:0]     fixed_mac_q, probe_mac_q;

  // Table chain
  scan_rec_t            rec [TABLE_ENTRIES];
  scan_rec_t            tail;
  entry_wr_t            wr;
  logic [IP_W-1:0]      query_ip;

  // Wait queue
  logic [WAIT_SLOTS-1:0] wait_valid_q;
  logic [IP_W-1:0]       wait_ip_q  [WAIT_SLOTS];
  logic [TAG_W-1:0]      wait_tag_q [WAIT_SLOTS];
  logic [WIDX_W-1:0]     w_idx_q, w_idx_d;
  logic                  wait_set, wait_clr;

  // Result buffer
  res_t                  res_q [RES_DEPTH];
  logic [RES_CNT_W-1:0]  res_cnt_q, res_cnt_d;
  logic [RES_IDX_W-1:0]  e_idx_q, e_idx_d;
  logic                  push_a_en, push_b_en;
  res_t                  push_a, push_b;
  logic                  emit_last;

  // Output registers
  logic                  strobe_q;
  res_t                  out_q;
  logic                  last_q;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // Take configuration writes; own MAC is accepted but not stored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q    <= '0;
      fixed_ip_q  <= FIXED_IP_RST;
      fixed_mac_q <= FIXED_MAC_RST;
      probe_mac_q <= PROBE_MAC_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_OWN_IP:    own_ip_q    <= cfg_wdata_i[IP_W-1:0];
        CFG_OWN_MAC:   ;
        CFG_FIXED_IP:  fixed_ip_q  <= cfg_wdata_i[IP_W-1:0];
        CFG_FIXED_MAC: fixed_mac_q <= cfg_wdata_i[MAC_W-1:0];
        CFG_PROBE_MAC: probe_mac_q <= cfg_wdata_i[MAC_W-1:0];
        default:       ;
      endcase
    end
  end

  // Latch the request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_e'(cmd_i);
      sip_q  <= sender_ip_i;
      smac_q <= sender_mac_i;
      tip_q  <= target_ip_i;
      tag_q  <= packet_tag_i;
    end
  end

  // Launch the lookup wave in the cycle after accept, unless the command is none
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_q <= 1'b0;
    end else begin
      launch_q <= accept && (cmd_e'(cmd_i) != CMD_NONE);
    end
  end

  assign query_ip = (cmd_q == CMD_RESOLVE) ? tip_q : sip_q;

  always_comb begin
    rec[0]         = '0;
    rec[0].live    = launch_q;
  end

  // Row of table cells, entry 0 being the static entry in configuration
  for (genvar k = 1; k < TABLE_ENTRIES; k++) begin : g_cell
    arp_cr_entry_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .query_ip_i (query_ip),
      .rec_i      (rec[k-1]),
      .rec_o      (rec[k]),
      .wr_i       (wr)
    );
  end

  assign tail = rec[TABLE_ENTRIES-1];

  // Learn the sender once the wave has passed all cells
  always_comb begin
    wr.en      = (state_q == S_SCAN) && tail.live
                 && ((cmd_q == CMD_REPLY) || (cmd_q == CMD_REQUEST))
                 && (sip_q != fixed_ip_q) && (tail.hit || tail.free);
    wr.sel_hit = tail.hit;
    wr.ip      = sip_q;
    wr.mac     = smac_q;
  end

  assign emit_last = (e_idx_q == RES_IDX_W'(res_cnt_q - 1'b1));

  // Sequence decision, wait queue scan and result emission
  always_comb begin
    state_d   = state_q;
    w_idx_d   = w_idx_q;
    e_idx_d   = e_idx_q;
    push_a_en = 1'b0;
    push_b_en = 1'b0;
    push_a    = '0;
    push_b    = '0;
    wait_set  = 1'b0;
    wait_clr  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (cmd_e'(cmd_i) != CMD_NONE)) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tail.live) begin
          w_idx_d = '0;
          unique case (cmd_q)
            CMD_REPLY: state_d = S_WAIT;
            CMD_REQUEST: begin
              if (tip_q == own_ip_q) begin
                push_a_en   = 1'b1;
                push_a.kind = KIND_REPLY;
                push_a.mac  = smac_q;
                push_a.ip   = sip_q;
                state_d     = S_EMIT;
              end else begin
                state_d = S_IDLE;
              end
            end
            CMD_RESOLVE: begin
              if (tip_q == fixed_ip_q) begin
                push_a_en   = 1'b1;
                push_a.kind = KIND_DATA;
                push_a.tag  = tag_q;
                push_a.mac  = fixed_mac_q;
                state_d     = S_EMIT;
              end else if (tail.hit) begin
                push_a_en   = 1'b1;
                push_a.kind = KIND_DATA;
                push_a.tag  = tag_q;
                push_a.mac  = tail.hit_mac;
                // Refresh probe when the cached MAC is the probe value
                if (tail.hit_mac == probe_mac_q) begin
                  push_b_en   = 1'b1;
                  push_b.kind = KIND_REQUEST;
                  push_b.mac  = BCAST_MAC;
                  push_b.ip   = tip_q;
                end
                state_d = S_EMIT;
              end else begin
                state_d = S_WAIT;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_WAIT: begin
        if (cmd_q == CMD_REPLY) begin
          // Release waiting packets for the sender, up to the buffer depth
          if (wait_valid_q[w_idx_q] && (wait_ip_q[w_idx_q] == sip_q)
              && (res_cnt_q < RES_CNT_W'(RES_DEPTH))) begin
            push_a_en   = 1'b1;
            push_a.kind = KIND_DATA;
            push_a.tag  = wait_tag_q[w_idx_q];
            push_a.mac  = smac_q;
            wait_clr    = 1'b1;
          end
          if (w_idx_q == WIDX_LAST) begin
            state_d = ((res_cnt_q != '0) || push_a_en) ? S_EMIT : S_IDLE;
          end else begin
            w_idx_d = w_idx_q + 1'b1;
          end
        end else begin
          // Queue the missed packet in the lowest free slot, or drop it
          if (!wait_valid_q[w_idx_q]) begin
            wait_set    = 1'b1;
            push_a_en   = 1'b1;
            push_a.kind = KIND_REQUEST;
            push_a.mac  = BCAST_MAC;
            push_a.ip   = tip_q;
            state_d     = S_EMIT;
          end else if (w_idx_q == WIDX_LAST) begin
            push_a_en   = 1'b1;
            push_a.kind = KIND_DROP;
            push_a.tag  = tag_q;
            push_b_en   = 1'b1;
            push_b.kind = KIND_REQUEST;
            push_b.mac  = BCAST_MAC;
            push_b.ip   = tip_q;
            state_d     = S_EMIT;
          end else begin
            w_idx_d = w_idx_q + 1'b1;
          end
        end
      end
      S_EMIT: begin
        if (emit_last) begin
          e_idx_d = '0;
          state_d = S_IDLE;
        end else begin
          e_idx_d = e_idx_q + 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase

    res_cnt_d = res_cnt_q + RES_CNT_W'(push_a_en) + RES_CNT_W'(push_b_en);
    if ((state_q == S_EMIT) && emit_last) begin
      res_cnt_d = '0;
    end
  end

  // Advance control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      w_idx_q   <= '0;
      e_idx_q   <= '0;
      res_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      w_idx_q   <= w_idx_d;
      e_idx_q   <= e_idx_d;
      res_cnt_q <= res_cnt_d;
    end
  end

  // Buffer results
  always_ff @(posedge clk_i) begin
    if (push_a_en) begin
      res_q[res_cnt_q[RES_IDX_W-1:0]] <= push_a;
    end
    if (push_b_en) begin
      res_q[res_cnt_q[RES_IDX_W-1:0] + 1'b1] <= push_b;
    end
  end

  // Hold wait slot valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_valid_q <= '0;
    end else if (wait_set) begin
      wait_valid_q[w_idx_q] <= 1'b1;
    end else if (wait_clr) begin
      wait_valid_q[w_idx_q] <= 1'b0;
    end
  end

  // Store the queued packet
  always_ff @(posedge clk_i) begin
    if (wait_set) begin
      wait_ip_q[w_idx_q]  <= tip_q;
      wait_tag_q[w_idx_q] <= tag_q;
    end
  end

  // Drive one result per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= (state_q == S_EMIT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EMIT) begin
      out_q  <= res_q[e_idx_q];
      last_q <= emit_last;
    end
  end

  assign strobe_o         = strobe_q;
  assign kind_o           = out_q.kind;
  assign packet_tag_res_o = out_q.tag;
  assign dest_mac_o       = out_q.mac;
  assign target_ip_res_o  = out_q.ip;
  assign last_o           = last_q;

  `include "arp_cache_resolver_unit_assert.svh"

  `ARP_CR_ASSERT_NXT(a_burst_contiguous, strobe_o && !last_o, strobe_o, "result burst broken")
  `ARP_CR_ASSERT_NXT(a_no_result_after_accept, accept, !strobe_o, "result right after accept")
  `ARP_CR_ASSERT_IMP(a_res_cnt_bound, 1'b1, res_cnt_q <= RES_CNT_W'(RES_DEPTH), "result count overflow")
  `ARP_CR_ASSERT_IMP(a_emit_nonempty, state_q == S_EMIT, res_cnt_q != '0, "emit with empty buffer")

endmodule

FILE: bench/tb_arp_cache_resolver_unit.sv
`timescale 1ns / 1ps

module tb_arp_cache_resolver_unit;
  import arp_cr_pkg::*;

  localparam int unsigned N_ENTRIES     = TABLE_ENTRIES_DEF;
  localparam int unsigned N_SLOTS       = WAIT_SLOTS_DEF;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned PHASE_ITEMS   = 120;
  localparam int unsigned POOL_IPS      = 10;
  localparam int unsigned MAX_REPORTS   = 40;

  typedef struct {
    cmd_e             cmd;
    logic [IP_W-1:0]  sender_ip;
    logic [MAC_W-1:0] sender_mac;
    logic [IP_W-1:0]  target_ip;
    logic [TAG_W-1:0] packet_tag;
  } arp_req_t;

  typedef struct {
    kind_e            kind;
    logic [TAG_W-1:0] tag;
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  ip;
    logic             last;
  } arp_action_t;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i  = '0;
  logic                  start        = 1'b0;
  logic                  busy;
  logic [1:0]            cmd_i        = '0;
  logic [IP_W-1:0]       sender_ip_i  = '0;
  logic [MAC_W-1:0]      sender_mac_i = '0;
  logic [IP_W-1:0]       target_ip_i  = '0;
  logic [TAG_W-1:0]      packet_tag_i = '0;
  logic                  strobe_o;
  logic [1:0]            kind_o;
  logic [TAG_W-1:0]      packet_tag_res_o;
  logic [MAC_W-1:0]      dest_mac_o;
  logic [IP_W-1:0]       target_ip_res_o;
  logic                  last_o;

  arp_cache_resolver_unit u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .start            (start),
    .busy             (busy),
    .cmd_i            (cmd_i),
    .sender_ip_i      (sender_ip_i),
    .sender_mac_i     (sender_mac_i),
    .target_ip_i      (target_ip_i),
    .packet_tag_i     (packet_tag_i),
    .strobe_o         (strobe_o),
    .kind_o           (kind_o),
    .packet_tag_res_o (packet_tag_res_o),
    .dest_mac_o       (dest_mac_o),
    .target_ip_res_o  (target_ip_res_o),
    .last_o           (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow registers and tables of the resolver
  logic [IP_W-1:0]  own_ip_q, fixed_ip_q;
  logic [MAC_W-1:0] own_mac_q, fixed_mac_q, probe_mac_q;
  logic             tbl_valid [N_ENTRIES];
  logic [IP_W-1:0]  tbl_ip    [N_ENTRIES];
  logic [MAC_W-1:0] tbl_mac   [N_ENTRIES];
  logic             wq_valid  [N_SLOTS];
  logic [IP_W-1:0]  wq_ip     [N_SLOTS];
  logic [TAG_W-1:0] wq_tag    [N_SLOTS];

  arp_req_t    req_backlog [$];
  arp_action_t actions_due [$];
  arp_req_t    req_cur;
  arp_action_t want;
  logic        launch_next;
  int unsigned n_queued     = 0;
  int unsigned n_taken      = 0;
  int unsigned gap_left     = 0;
  int unsigned burst_left   = 0;
  int unsigned stall_cycles = 0;
  int unsigned mismatches   = 0;

  logic [IP_W-1:0]  ip_pool [POOL_IPS];

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[MAC_W-1:0];
  endfunction

  // Learn a sender unless it is the static entry or the table is full
  function automatic void learn_sender(logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
    int slot;
    int i;
    slot = -1;
    if (ip == fixed_ip_q) return;
    for (i = 1; i < N_ENTRIES; i++)
      if (slot < 0 && tbl_valid[i] && tbl_ip[i] == ip) slot = i;
    for (i = 1; i < N_ENTRIES; i++)
      if (slot < 0 && !tbl_valid[i]) slot = i;
    if (slot < 0) return;
    tbl_valid[slot] = 1'b1;
    tbl_ip[slot]    = ip;
    tbl_mac[slot]   = mac;
  endfunction

  function automatic void push_action(kind_e kind, logic [TAG_W-1:0] tag,
                                      logic [MAC_W-1:0] mac, logic [IP_W-1:0] ip);
    arp_action_t a;
    a.kind = kind;
    a.tag  = tag;
    a.mac  = mac;
    a.ip   = ip;
    a.last = 1'b0;
    actions_due.push_back(a);
  endfunction

  // Update the shadow state for one request and queue the actions it causes
  function automatic void predict_actions(arp_req_t r);
    int base;
    int hit;
    int slot;
    int i;
    base = actions_due.size();
    hit  = -1;
    slot = -1;
    case (r.cmd)
      CMD_REPLY: begin
        learn_sender(r.sender_ip, r.sender_mac);
        for (i = 0; i < N_SLOTS; i++) begin
          if (actions_due.size() - base < RES_DEPTH && wq_valid[i] &&
              wq_ip[i] == r.sender_ip) begin
            push_action(KIND_DATA, wq_tag[i], r.sender_mac, '0);
            wq_valid[i] = 1'b0;
          end
        end
      end
      CMD_REQUEST: begin
        learn_sender(r.sender_ip, r.sender_mac);
        if (r.target_ip == own_ip_q) push_action(KIND_REPLY, '0, r.sender_mac, r.sender_ip);
      end
      CMD_RESOLVE: begin
        if (r.target_ip == fixed_ip_q) begin
          push_action(KIND_DATA, r.packet_tag, fixed_mac_q, '0);
        end else begin
          for (i = 1; i < N_ENTRIES; i++)
            if (hit < 0 && tbl_valid[i] && tbl_ip[i] == r.target_ip) hit = i;
          if (hit >= 0) begin
            push_action(KIND_DATA, r.packet_tag, tbl_mac[hit], '0);
            if (tbl_mac[hit] == probe_mac_q) push_action(KIND_REQUEST, '0, BCAST_MAC, r.target_ip);
          end else begin
            for (i = 0; i < N_SLOTS; i++)
              if (slot < 0 && !wq_valid[i]) slot = i;
            if (slot >= 0) begin
              wq_valid[slot] = 1'b1;
              wq_ip[slot]    = r.target_ip;
              wq_tag[slot]   = r.packet_tag;
            end else begin
              push_action(KIND_DROP, r.packet_tag, '0, '0);
            end
            push_action(KIND_REQUEST, '0, BCAST_MAC, r.target_ip);
          end
        end
      end
      default: ;
    endcase
    if (actions_due.size() > base) actions_due[actions_due.size() - 1].last = 1'b1;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a back-to-back burst
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      burst_left = $urandom_range(8, 30);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(15, 70);
  endfunction

  // Drive requests from the backlog, hold each until it is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start        <= 1'b0;
      cmd_i        <= '0;
      sender_ip_i  <= '0;
      sender_mac_i <= '0;
      target_ip_i  <= '0;
      packet_tag_i <= '0;
      gap_left     = 0;
    end else begin
      launch_next = start;
      if (start && !busy) begin
        predict_actions(req_cur);
        n_taken++;
        launch_next = 1'b0;
        gap_left = pick_gap();
      end
      if (!launch_next) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_backlog.size() > 0) begin
          req_cur      = req_backlog.pop_front();
          launch_next  = 1'b1;
          cmd_i        <= req_cur.cmd;
          sender_ip_i  <= req_cur.sender_ip;
          sender_mac_i <= req_cur.sender_mac;
          target_ip_i  <= req_cur.target_ip;
          packet_tag_i <= req_cur.packet_tag;
        end
      end
      start <= launch_next;
    end
  end

  function automatic void check_field(string what, logic [63:0] want_v, logic [63:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %h, got %h", $time, what, want_v, got_v);
    end
  endfunction

  // Compare each strobed result with the oldest expected action; watch for a hang
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_cycles = 0;
    end else begin
      if (strobe_o) begin
        if (actions_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result with nothing expected: expected none, got kind %0d tag %h mac %h ip %h",
                     $time, kind_o, packet_tag_res_o, dest_mac_o, target_ip_res_o);
        end else begin
          want = actions_due.pop_front();
          check_field("kind", 64'(want.kind), 64'(kind_o));
          check_field("packet_tag_res", 64'(want.tag), 64'(packet_tag_res_o));
          check_field("dest_mac", 64'(want.mac), 64'(dest_mac_o));
          check_field("target_ip_res", 64'(want.ip), 64'(target_ip_res_o));
          check_field("last", 64'(want.last), 64'(last_o));
        end
      end
      if ((start && !busy) || strobe_o) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic queue_req(cmd_e cmd, logic [IP_W-1:0] sip, logic [MAC_W-1:0] smac,
                           logic [IP_W-1:0] tip, logic [TAG_W-1:0] tag);
    arp_req_t r;
    r.cmd        = cmd;
    r.sender_ip  = sip;
    r.sender_mac = smac;
    r.target_ip  = tip;
    r.packet_tag = tag;
    req_backlog.push_back(r);
    n_queued++;
  endtask

  // Wait until every request is taken and answered, then let the block go quiet
  task automatic settle();
    while (n_taken != n_queued || actions_due.size() != 0 || busy) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_OWN_IP:    own_ip_q    = val[IP_W-1:0];
      CFG_OWN_MAC:   own_mac_q   = val[MAC_W-1:0];
      CFG_FIXED_IP:  fixed_ip_q  = val[IP_W-1:0];
      CFG_FIXED_MAC: fixed_mac_q = val[MAC_W-1:0];
      CFG_PROBE_MAC: probe_mac_q = val[MAC_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(logic [IP_W-1:0] oip, logic [MAC_W-1:0] omac,
                              logic [IP_W-1:0] fip, logic [MAC_W-1:0] fmac,
                              logic [MAC_W-1:0] pmac);
    write_reg(CFG_OWN_IP, CFG_DATA_W'(oip));
    write_reg(CFG_OWN_MAC, omac);
    write_reg(CFG_FIXED_IP, CFG_DATA_W'(fip));
    write_reg(CFG_FIXED_MAC, fmac);
    write_reg(CFG_PROBE_MAC, pmac);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [IP_W-1:0] pick_ip();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return ip_pool[$urandom_range(0, POOL_IPS - 1)];
    if (r < 80) return fixed_ip_q;
    return $urandom;
  endfunction

  function automatic logic [MAC_W-1:0] pick_mac();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return probe_mac_q;
    if (r < 20) return fixed_mac_q;
    if (r < 23) return '0;
    if (r < 26) return '1;
    return rand_mac();
  endfunction

  // Random traffic over a small address pool so that misses, releases and hits mix
  task automatic run_random_phase();
    int unsigned done;
    int unsigned r;
    int unsigned i;
    cmd_e        cmd;
    done = 0;
    for (i = 0; i < POOL_IPS; i++) ip_pool[i] = $urandom;
    ip_pool[0] = own_ip_q;
    while (done < PHASE_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 38) cmd = CMD_RESOLVE;
      else if (r < 68) cmd = CMD_REPLY;
      else if (r < 95) cmd = CMD_REQUEST;
      else cmd = CMD_NONE;
      queue_req(cmd, pick_ip(), pick_mac(),
                ($urandom_range(0, 2) == 0) ? own_ip_q : pick_ip(), TAG_W'($urandom));
      if (cmd != CMD_NONE) done++;
    end
  endtask

  initial begin
    int unsigned k;
    logic [IP_W-1:0] ip_a, ip_b, ip_c, ip_d;
    ip_a = 32'h0A00_0001;
    ip_b = 32'hC0A8_0101;
    ip_c = 32'hFFFF_FFFF;
    ip_d = 32'h0000_0000;
    own_ip_q    = '0;
    own_mac_q   = '0;
    fixed_ip_q  = FIXED_IP_RST;
    fixed_mac_q = FIXED_MAC_RST;
    probe_mac_q = PROBE_MAC_RST;
    for (k = 0; k < N_ENTRIES; k++) begin
      tbl_valid[k] = 1'b0;
      tbl_ip[k]    = '0;
      tbl_mac[k]   = '0;
    end
    for (k = 0; k < N_SLOTS; k++) begin
      wq_valid[k] = 1'b0;
      wq_ip[k]    = '0;
      wq_tag[k]   = '0;
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Static hit, fill the wait queue, then overflow it
    queue_req(CMD_RESOLVE, '0, '0, FIXED_IP_RST, 16'hFFFF);
    queue_req(CMD_RESOLVE, '0, '0, ip_a, 16'h0000);
    queue_req(CMD_RESOLVE, '0, '0, ip_a, 16'h0001);
    queue_req(CMD_RESOLVE, '0, '0, ip_c, 16'h0002);
    queue_req(CMD_RESOLVE, '0, '0, ip_a, 16'h0003);
    queue_req(CMD_RESOLVE, '0, '0, ip_b, 16'h0004);
    // Reply releases every waiting packet for its sender in slot order
    queue_req(CMD_REPLY, ip_a, '1, '1, '1);
    queue_req(CMD_RESOLVE, '0, '0, ip_a, 16'h0005);
    // Request from the static address: answered, never learned
    queue_req(CMD_REQUEST, FIXED_IP_RST, rand_mac(), '0, '0);
    // Learn the probe MAC, hit it, then overwrite the entry
    queue_req(CMD_REQUEST, ip_b, PROBE_MAC_RST, 32'h0000_0001, '0);
    queue_req(CMD_RESOLVE, '0, '0, ip_b, 16'h0006);
    queue_req(CMD_REQUEST, ip_b, '0, '0, '0);
    queue_req(CMD_RESOLVE, '0, '0, ip_b, 16'h0007);
    queue_req(CMD_NONE, '1, '1, '1, '1);
    queue_req(CMD_REPLY, ip_c, rand_mac(), '0, '0);
    // Four packets for one address, released by a single reply
    for (k = 0; k < N_SLOTS; k++) queue_req(CMD_RESOLVE, '0, '0, ip_d, TAG_W'(8 + k));
    queue_req(CMD_REPLY, ip_d, PROBE_MAC_RST, '0, '0);
    queue_req(CMD_RESOLVE, '0, '0, ip_d, 16'h000C);
    queue_req(CMD_REPLY, 32'h8000_0000, 48'h8000_0000_0000, '0, '0);
    settle();

    // Static entry moved onto a learned address
    program_regs($urandom, rand_mac(), ip_a, rand_mac(), '0);
    queue_req(CMD_RESOLVE, '0, '0, ip_a, 16'h1234);
    queue_req(CMD_REPLY, ip_a, rand_mac(), '0, '0);
    run_random_phase();
    settle();

    program_regs('0, '0, '0, '0, '0);
    run_random_phase();
    settle();

    program_regs('1, '1, '1, '1, '1);
    run_random_phase();
    settle();

    program_regs($urandom, rand_mac(), $urandom, rand_mac(), rand_mac());
    run_random_phase();
    settle();

    if (mismatches == 0 && actions_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
